/* rtl/assert_macros.svh */
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked each clock, reset masked
`define ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("assertion failed");
`endif

/* rtl/x86ex_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86ex_pkg
// shared types and constants of the instruction execute block
// ----------------------------------------------------------------------------
package x86ex_pkg;
   localparam logic [4:0] CMD_MOV = 5'd0;
   localparam logic [4:0] CMD_ADD = 5'd1;
   localparam logic [4:0] CMD_SUB = 5'd2;
   localparam logic [4:0] CMD_CMP = 5'd3;
   localparam logic [4:0] CMD_JMP = 5'd4;
   localparam logic [4:0] CMD_JCC_LAST = 5'd20;
   localparam logic [4:0] CMD_LOOP = 5'd21;
   localparam logic [4:0] CMD_LOOPZ = 5'd22;
   localparam logic [4:0] CMD_LOOPNZ = 5'd23;
   localparam logic [4:0] CMD_JCXZ = 5'd24;
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_REG = 2'd1;
   localparam logic [1:0] KIND_IMM = 2'd2;
   localparam logic [1:0] KIND_MEM = 2'd3;
   localparam logic [1:0] PART_WORD = 2'd0;
   localparam logic [1:0] PART_HIGH = 2'd1;
   localparam logic [3:0] REG_IP = 4'd8;
   localparam logic [3:0] REG_NONE = 4'd9;
   localparam logic [2:0] CX_INDEX = 3'd1;
   localparam logic [11:0] FL_ARITH = 12'h8D5;
   localparam int FL_C = 0;
   localparam int FL_P = 2;
   localparam int FL_A = 4;
   localparam int FL_Z = 6;
   localparam int FL_S = 7;
   localparam int FL_O = 11;

   typedef struct packed {
      logic [4:0]  command;
      logic [1:0]  dest_kind;
      logic [2:0]  dest_reg;
      logic [1:0]  dest_part;
      logic [1:0]  src_kind;
      logic [2:0]  src_reg;
      logic [1:0]  src_part;
      logic [15:0] imm;
      logic [3:0]  base_a;
      logic [3:0]  base_b;
      logic [16:0] disp;
      logic [2:0]  len;
   } instr_type;

   typedef struct packed {
      logic [15:0] old_ip;
      logic [15:0] new_ip;
      logic [11:0] old_fl;
      logic [11:0] new_fl;
      logic [3:0]  wreg;
      logic [15:0] oldv;
      logic [15:0] newv;
      logic        jump;
      logic        fault;
   } result_type;

   // byte lane select of a 16-bit register
   function automatic logic [15:0] read_part(input logic [15:0] v, input logic [1:0] p);
      logic [15:0] r;
      if (p == PART_WORD) r = v;
      else if (p == PART_HIGH) r = {8'h00, v[15:8]};
      else r = {8'h00, v[7:0]};
      return r;
   endfunction
endpackage

/* rtl/x86ex_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86ex_ram
// generic single-port-write, one-read synchronous ram
// ----------------------------------------------------------------------------
module x86ex_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

/* rtl/x86ex_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86ex_alu
// add / subtract with x86 flags at byte or word width
// ----------------------------------------------------------------------------
module x86ex_alu (
   input  logic [15:0] a,
   input  logic [15:0] b,
   input  logic        sub,
   input  logic        wide,
   output logic [15:0] res,
   output logic [11:0] flags
);
   import x86ex_pkg::*;
   logic [15:0] am, bm;
   logic [16:0] full;
   logic [15:0] r;
   logic [4:0]  nib;
   logic        top_a, top_b, top_r;

   // operand masking and sum
   always_comb begin
      am = wide ? a : {8'h00, a[7:0]};
      bm = wide ? b : {8'h00, b[7:0]};
      full = sub ? ({1'b0, am} - {1'b0, bm}) : ({1'b0, am} + {1'b0, bm});
      r = wide ? full[15:0] : {8'h00, full[7:0]};
      nib = sub ? ({1'b0, am[3:0]} - {1'b0, bm[3:0]}) : ({1'b0, am[3:0]} + {1'b0, bm[3:0]});
      top_a = wide ? am[15] : am[7];
      top_b = wide ? bm[15] : bm[7];
      top_r = wide ? r[15] : r[7];
      flags = '0;
      flags[FL_C] = wide ? full[16] : full[8];
      flags[FL_A] = nib[4];
      flags[FL_Z] = (r == 16'h0000);
      flags[FL_S] = top_r;
      flags[FL_O] = sub ? ((top_a ^ top_b) & (top_a ^ top_r))
                        : ((top_a ^ top_r) & (top_b ^ top_r));
      flags[FL_P] = ~^r[7:0];
      res = r;
   end
endmodule

/* rtl/x86_16bit_instruction_execute.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// x86_16bit_instruction_execute
// executes one pre-decoded 16-bit x86 instruction per transfer
// ----------------------------------------------------------------------------
// channel | dir | contents
// req_    | in  | pre-decoded instruction, 72 bits of tdata
// rsp_    | out | register / ip / flag change record, 96 bits of tdata
//
// a transfer is accepted at the edge that also starts the memory word read;
// the execute edge, once rsp_ has room, writes the bytes back and loads rsp_.
// transfers can follow back to back at one per cycle, execute overlapping
// the read of the next one, with register and byte forwarding between them.
// memory is cleared after reset by a pass over the 2**(MEM_ADDR_BITS-1) words of
// each bank, during which req_tready is low. a full output register stalls execute.
module x86_16bit_instruction_execute #(
   parameter int MEM_ADDR_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command, dest_kind, dest_reg, dest_part, src_kind, src_reg, src_part,
   // imm_value, addr_base_a, addr_base_b, addr_disp, instr_length
   input  logic [71:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // old_ip, new_ip, old_flag_word, new_flag_word, written_reg, old_reg_value,
   // new_reg_value, jump_taken, fault
   output logic [95:0]  rsp_tdata
);
   import x86ex_pkg::*;
   localparam int AW = MEM_ADDR_BITS;
   localparam int DEPTH = 1 << AW;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_RUN   = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [AW-2:0] clr_ff, clr_in;
   logic [15:0] regs_ff [8];
   logic [15:0] ip_ff;
   logic [11:0] fl_ff;
   instr_type   ins_ff, in_ins;
   logic [AW-1:0] addr_ff, addr_in;
   logic        rsp_valid_ff;
   result_type  rsp_ff, res;
   logic [7:0]  lo_q, hi_q;
   logic        accept, exec_go;

   // unpack request
   always_comb begin
      in_ins.command   = req_tdata[4:0];
      in_ins.dest_kind = req_tdata[6:5];
      in_ins.dest_reg  = req_tdata[9:7];
      in_ins.dest_part = req_tdata[11:10];
      in_ins.src_kind  = req_tdata[13:12];
      in_ins.src_reg   = req_tdata[16:14];
      in_ins.src_part  = req_tdata[18:17];
      in_ins.imm       = req_tdata[34:19];
      in_ins.base_a    = req_tdata[39:36];
      in_ins.base_b    = req_tdata[43:40];
      in_ins.disp      = req_tdata[60:44];
      in_ins.len       = req_tdata[63:61];
   end

   // effective address, register written by the executing transfer forwarded
   always_comb begin
      logic [AW-1:0] a;
      logic [15:0]   va, vb;
      va = regs_ff[in_ins.base_a[2:0]];
      vb = regs_ff[in_ins.base_b[2:0]];
      if (exec_go && !res.wreg[3] && res.wreg[2:0] == in_ins.base_a[2:0]) va = res.newv;
      if (exec_go && !res.wreg[3] && res.wreg[2:0] == in_ins.base_b[2:0]) vb = res.newv;
      a = AW'($signed(in_ins.disp));
      if (!in_ins.base_a[3]) a = a + AW'(va);
      if (!in_ins.base_b[3]) a = a + AW'(vb);
      addr_in = a;
   end

   assign exec_go = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == ST_RUN) || exec_go;
   assign accept = req_tvalid && req_tready;

   // execute stage
   logic        dwide, alu_sub;
   logic [15:0] src, cur, alu_r, mword, oldv, wv, cx1;
   logic [11:0] alu_f;
   logic        mem_we_lo, mem_we_hi;
   logic [7:0]  wd_lo, wd_hi;
   logic        ccv;

   x86ex_alu u_alu (
      .a(cur), .b(src), .sub(alu_sub), .wide(dwide), .res(alu_r), .flags(alu_f)
   );

   always_comb begin
      dwide = (ins_ff.dest_part == PART_WORD);
      mword = {hi_q, lo_q};
      src = '0;
      case (ins_ff.src_kind)
         KIND_REG: src = read_part(regs_ff[ins_ff.src_reg], ins_ff.src_part);
         KIND_IMM: src = ins_ff.imm;
         KIND_MEM: src = dwide ? mword : {8'h00, lo_q};
         default:  src = '0;
      endcase
      if (!dwide) src = {8'h00, src[7:0]};
      oldv = regs_ff[ins_ff.dest_reg];
      cur = (ins_ff.dest_kind == KIND_MEM) ? mword : read_part(oldv, ins_ff.dest_part);
      alu_sub = (ins_ff.command != CMD_ADD);
      // condition evaluation, code = command - 5
      begin
         logic [4:0] cc;
         logic c, z, s, o, p, t;
         cc = ins_ff.command - 5'd5;
         c = fl_ff[FL_C]; z = fl_ff[FL_Z]; s = fl_ff[FL_S];
         o = fl_ff[FL_O]; p = fl_ff[FL_P];
         case (cc[3:1])
            3'd0: t = o;
            3'd1: t = c;
            3'd2: t = z;
            3'd3: t = c | z;
            3'd4: t = s;
            3'd5: t = p;
            3'd6: t = s ^ o;
            default: t = (s ^ o) | z;
         endcase
         ccv = cc[0] ? ~t : t;
      end
      cx1 = regs_ff[CX_INDEX] - 16'd1;

      res.old_ip = ip_ff;
      res.new_ip = ip_ff + {13'd0, ins_ff.len};
      res.old_fl = fl_ff;
      res.new_fl = fl_ff;
      res.wreg = REG_NONE;
      res.oldv = '0;
      res.newv = '0;
      res.jump = 1'b0;
      res.fault = 1'b0;
      mem_we_lo = 1'b0;
      mem_we_hi = 1'b0;
      wv = src;
      case (ins_ff.dest_kind)
         KIND_REG: begin
            if (ins_ff.command > CMD_CMP) res.fault = 1'b1;
            else begin
               logic [15:0] r;
               r = src;
               if (ins_ff.command != CMD_MOV)
                  res.new_fl = (fl_ff & ~FL_ARITH) | alu_f;
               if (ins_ff.command == CMD_ADD || ins_ff.command == CMD_SUB) r = alu_r;
               if (ins_ff.command == CMD_CMP) r = cur;
               res.oldv = oldv;
               if (dwide) res.newv = r;
               else if (ins_ff.dest_part == PART_HIGH) res.newv = {r[7:0], oldv[7:0]};
               else res.newv = {oldv[15:8], r[7:0]};
               res.wreg = {1'b0, ins_ff.dest_reg};
            end
         end
         KIND_IMM: begin
            if (ins_ff.command < CMD_JMP || ins_ff.command > CMD_JCXZ) res.fault = 1'b1;
            else begin
               if (ins_ff.command == CMD_JMP) res.jump = 1'b1;
               else if (ins_ff.command <= CMD_JCC_LAST) res.jump = ccv;
               else begin
                  res.wreg = {1'b0, CX_INDEX};
                  res.oldv = regs_ff[CX_INDEX];
                  res.newv = (ins_ff.command == CMD_JCXZ) ? regs_ff[CX_INDEX] : cx1;
                  case (ins_ff.command)
                     CMD_LOOP:   res.jump = (cx1 != 16'd0);
                     CMD_LOOPZ:  res.jump = (cx1 != 16'd0) && fl_ff[FL_Z];
                     CMD_LOOPNZ: res.jump = (cx1 != 16'd0) && !fl_ff[FL_Z];
                     default:    res.jump = (regs_ff[CX_INDEX] == 16'd0);
                  endcase
               end
               if (res.jump) res.new_ip = res.new_ip + ins_ff.imm;
               if (ins_ff.command <= CMD_JCC_LAST) begin
                  res.wreg = REG_IP;
                  res.oldv = ip_ff;
                  res.newv = res.new_ip;
               end
            end
         end
         KIND_MEM: begin
            if (ins_ff.command == CMD_MOV || ins_ff.command == CMD_ADD) begin
               wv = (ins_ff.command == CMD_ADD) ? alu_r : src;
               mem_we_lo = 1'b1;
               mem_we_hi = dwide;
            end else if (ins_ff.command == CMD_JMP) begin
               res.new_ip = mword;
               res.jump = 1'b1;
               res.wreg = REG_IP;
               res.oldv = ip_ff;
               res.newv = mword;
            end else res.fault = 1'b1;
         end
         default: res.fault = 1'b0;
      endcase
      wd_lo = wv[7:0];
      wd_hi = wv[15:8];
      // the adder runs at byte width for byte stores: low byte only written
   end

   // memory: low byte lane at addr, high byte lane at addr+1
   logic [AW-1:0] hi_addr_rd, hi_addr_ff;
   logic          w_lo, w_hi;
   logic [AW-1:0] wa_lo, wa_hi;
   logic [7:0]    wdl, wdh;
   logic [AW-1:0] rd_lo_addr, rd_hi_addr;

   assign hi_addr_rd = addr_in + AW'(1);

   // read address held on the accepted transfer while it waits
   assign rd_lo_addr = accept ? addr_in : addr_ff;
   assign rd_hi_addr = accept ? hi_addr_rd : hi_addr_ff;

   // byte writes of the execute cycle
   always_comb begin
      w_lo = exec_go && mem_we_lo;
      w_hi = exec_go && mem_we_hi;
      wa_lo = addr_ff; wa_hi = hi_addr_ff;
      wdl = wd_lo; wdh = wd_hi;
   end

   // bytes live in a pair of banks split by address bit 0
   logic [AW-2:0] ev_rd, od_rd, ev_wa, od_wa;
   logic          ev_we, od_we;
   logic [7:0]    ev_wd, od_wd, ev_q, od_q;
   logic [7:0]    lo_raw, hi_raw;
   logic          par_ff;

   always_comb begin
      // even address bank: reads the byte at the even one of addr, addr+1
      ev_rd = rd_lo_addr[0] ? rd_hi_addr[AW-1:1] : rd_lo_addr[AW-1:1];
      od_rd = rd_lo_addr[AW-1:1];
      if (state_ff == ST_CLEAR) begin
         ev_we = 1'b1; od_we = 1'b1;
         ev_wa = clr_ff; od_wa = clr_ff;
         ev_wd = '0; od_wd = '0;
      end else if (addr_ff[0]) begin
         od_we = w_lo; od_wa = wa_lo[AW-1:1]; od_wd = wdl;
         ev_we = w_hi; ev_wa = wa_hi[AW-1:1]; ev_wd = wdh;
      end else begin
         ev_we = w_lo; ev_wa = wa_lo[AW-1:1]; ev_wd = wdl;
         od_we = w_hi; od_wa = wa_hi[AW-1:1]; od_wd = wdh;
      end
      lo_raw = par_ff ? od_q : ev_q;
      hi_raw = par_ff ? ev_q : od_q;
   end

   x86ex_ram #(.WIDTH(8), .DEPTH(DEPTH / 2)) u_even (
      .clock(clock), .wr_en(ev_we), .wr_addr(ev_wa), .wr_data(ev_wd),
      .rd_addr(ev_rd), .rd_data(ev_q)
   );
   x86ex_ram #(.WIDTH(8), .DEPTH(DEPTH / 2)) u_odd (
      .clock(clock), .wr_en(od_we), .wr_addr(od_wa), .wr_data(od_wd),
      .rd_addr(od_rd), .rd_data(od_q)
   );

   // last byte writes, forwarded over a read issued at the same edge
   logic          fwd_lo_we_ff, fwd_hi_we_ff;
   logic [AW-1:0] fwd_lo_addr_ff, fwd_hi_addr_ff;
   logic [7:0]    fwd_lo_data_ff, fwd_hi_data_ff;

   always_comb begin
      lo_q = lo_raw;
      hi_q = hi_raw;
      if (fwd_lo_we_ff && fwd_lo_addr_ff == addr_ff) lo_q = fwd_lo_data_ff;
      if (fwd_hi_we_ff && fwd_hi_addr_ff == addr_ff) lo_q = fwd_hi_data_ff;
      if (fwd_lo_we_ff && fwd_lo_addr_ff == hi_addr_ff) hi_q = fwd_lo_data_ff;
      if (fwd_hi_we_ff && fwd_hi_addr_ff == hi_addr_ff) hi_q = fwd_hi_data_ff;
   end

   // control state
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + (AW-1)'(1);
            if (clr_ff == '1) state_in = ST_RUN;
         end
         ST_RUN: if (accept) state_in = ST_EXEC;
         ST_EXEC: if (exec_go && !accept) state_in = ST_RUN;
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         ip_ff <= '0;
         fl_ff <= '0;
         fwd_lo_we_ff <= 1'b0;
         fwd_hi_we_ff <= 1'b0;
         for (int i = 0; i < 8; i++) regs_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         if (exec_go) begin
            rsp_valid_ff <= 1'b1;
            ip_ff <= res.new_ip;
            fl_ff <= res.new_fl;
            fwd_lo_we_ff <= w_lo;
            fwd_hi_we_ff <= w_hi;
            if (res.wreg[3] == 1'b0) regs_ff[res.wreg[2:0]] <= res.newv;
         end else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ins_ff <= in_ins;
         addr_ff <= addr_in;
         hi_addr_ff <= hi_addr_rd;
         par_ff <= addr_in[0];
      end
      if (exec_go) begin
         rsp_ff <= res;
         fwd_lo_addr_ff <= wa_lo;
         fwd_hi_addr_ff <= wa_hi;
         fwd_lo_data_ff <= wdl;
         fwd_hi_data_ff <= wdh;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {2'b00, rsp_ff.fault, rsp_ff.jump, rsp_ff.newv, rsp_ff.oldv,
                       rsp_ff.wreg, rsp_ff.new_fl, rsp_ff.old_fl, rsp_ff.new_ip,
                       rsp_ff.old_ip};

   `ASSERT_IMP(a_no_accept_clear, clock, reset, state_ff == ST_CLEAR, !req_tready)
   `ASSERT_NXT(a_exec_valid, clock, reset, exec_go, rsp_tvalid)
   `ASSERT_IMP(a_hold_full, clock, reset, rsp_tvalid && !rsp_tready && state_ff == ST_EXEC, !req_tready)
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for x86_16bit_instruction_execute. Directed and random
// pre-decoded instructions are driven on the req_ stream. A local copy of the
// registers, the ip, the flags and the byte memory predicts each rsp_ record,
// and every field of the record is compared.
// ----------------------------------------------------------------------------
module tb_top;
   import x86ex_pkg::*;

   localparam int RES_BITS = 94;

   typedef bit [RES_BITS-1:0] record_type;

   // ------------------------------------------------------------------------
   // shadow machine and queue of predicted change records
   // ------------------------------------------------------------------------
   class exec_scoreboard;
      bit [15:0] gpr [8];
      bit [15:0] ip;
      bit [11:0] flags;
      bit [7:0]  mem [65536];
      record_type pending_records [$];
      int        errors;

      function bit [15:0] lane(bit [15:0] v, bit [1:0] p);
         if (p == PART_WORD) return v;
         if (p == PART_HIGH) return {8'h00, v[15:8]};
         return {8'h00, v[7:0]};
      endfunction

      function bit [15:0] mem_rd(bit [15:0] a, bit wide);
         bit [15:0] a1;
         a1 = a + 16'd1;
         return wide ? {mem[a1], mem[a]} : {8'h00, mem[a]};
      endfunction

      function void mem_wr(bit [15:0] a, bit [15:0] v, bit wide);
         bit [15:0] a1;
         a1 = a + 16'd1;
         mem[a] = v[7:0];
         if (wide) mem[a1] = v[15:8];
      endfunction

      // add or subtract at byte or word width, returns the six flags
      function bit [11:0] alu(bit [15:0] a, bit [15:0] b, bit sub, bit wide,
                              output bit [15:0] r);
         bit [16:0] full;
         bit [15:0] m, top;
         bit [11:0] f;
         m = wide ? 16'hFFFF : 16'h00FF;
         top = wide ? 16'h8000 : 16'h0080;
         f = '0;
         a &= m;
         b &= m;
         full = sub ? {1'b0, a} - {1'b0, b} : {1'b0, a} + {1'b0, b};
         r = full[15:0] & m;
         f[FL_C] = sub ? (a < b) : (full > {1'b0, m});
         f[FL_A] = sub ? (a[3:0] < b[3:0]) : (({1'b0, a[3:0]} + b[3:0]) > 5'd15);
         f[FL_Z] = (r == 0);
         f[FL_S] = |(r & top);
         f[FL_O] = sub ? |((a ^ b) & (a ^ r) & top) : |((a ^ r) & (b ^ r) & top);
         f[FL_P] = ~^r[7:0];
         return f;
      endfunction

      function bit jcc_true(bit [4:0] cc, bit [11:0] fl);
         bit t;
         case (cc[3:1])
            3'd0: t = fl[FL_O];
            3'd1: t = fl[FL_C];
            3'd2: t = fl[FL_Z];
            3'd3: t = fl[FL_C] | fl[FL_Z];
            3'd4: t = fl[FL_S];
            3'd5: t = fl[FL_P];
            3'd6: t = fl[FL_S] ^ fl[FL_O];
            default: t = (fl[FL_S] ^ fl[FL_O]) | fl[FL_Z];
         endcase
         return cc[0] ? !t : t;
      endfunction

      // execute one accepted instruction and queue its record
      function void note_instr(bit [63:0] d);
         bit [4:0] cmd;
         bit [1:0] dk, dp, sk, sp;
         bit [2:0] dr, sr, len;
         bit [15:0] imm, addr, src, cur, r, oldv, newv, old_ip, new_ip, cx;
         bit [3:0] ba, bb, wreg;
         bit [11:0] old_fl, new_fl;
         bit jump, fault, dwide;
         cmd = d[4:0];   dk = d[6:5];    dr = d[9:7];    dp = d[11:10];
         sk = d[13:12];  sr = d[16:14];  sp = d[18:17];  imm = d[34:19];
         ba = d[39:36];  bb = d[43:40];  addr = d[59:44]; len = d[63:61];
         old_ip = ip;
         new_ip = ip + len;
         old_fl = flags;
         new_fl = flags;
         wreg = REG_NONE;
         oldv = 0; newv = 0; jump = 0; fault = 0;
         dwide = (dp == PART_WORD);
         if (ba < 8) addr += gpr[ba[2:0]];
         if (bb < 8) addr += gpr[bb[2:0]];
         // source operand, cut to a byte for byte destinations
         src = 0;
         if (sk == KIND_REG) src = lane(gpr[sr], sp);
         else if (sk == KIND_IMM) src = imm;
         else if (sk == KIND_MEM) src = mem_rd(addr, dwide);
         if (!dwide) src &= 16'h00FF;
         if (dk == KIND_REG) begin
            if (cmd > CMD_CMP) fault = 1;
            else begin
               cur = lane(gpr[dr], dp);
               r = src;
               oldv = gpr[dr];
               if (cmd != CMD_MOV)
                  new_fl = (old_fl & ~FL_ARITH) | alu(cur, src, cmd != CMD_ADD, dwide, r);
               if (cmd == CMD_CMP) r = cur;
               if (dp == PART_WORD) newv = r;
               else if (dp == PART_HIGH) newv = {r[7:0], oldv[7:0]};
               else newv = {oldv[15:8], r[7:0]};
               gpr[dr] = newv;
               flags = new_fl;
               wreg = {1'b0, dr};
            end
         end else if (dk == KIND_IMM) begin
            if (cmd < CMD_JMP || cmd > CMD_JCXZ) fault = 1;
            else begin
               if (cmd == CMD_JMP) jump = 1;
               else if (cmd <= CMD_JCC_LAST) jump = jcc_true(cmd - 5'd5, old_fl);
               else begin
                  cx = gpr[CX_INDEX];
                  wreg = {1'b0, CX_INDEX};
                  oldv = cx;
                  newv = (cmd == CMD_JCXZ) ? cx : cx - 16'd1;
                  gpr[CX_INDEX] = newv;
                  case (cmd)
                     CMD_LOOP:  jump = (newv != 0);
                     CMD_LOOPZ: jump = (newv != 0) && old_fl[FL_Z];
                     CMD_LOOPNZ: jump = (newv != 0) && !old_fl[FL_Z];
                     default:   jump = (newv == 0);
                  endcase
               end
               if (jump) new_ip += imm;
               if (cmd <= CMD_JCC_LAST) begin
                  wreg = REG_IP;
                  oldv = old_ip;
                  newv = new_ip;
               end
            end
         end else if (dk == KIND_MEM) begin
            if (cmd == CMD_MOV) mem_wr(addr, src, dwide);
            else if (cmd == CMD_ADD) mem_wr(addr, mem_rd(addr, dwide) + src, dwide);
            else if (cmd == CMD_JMP) begin
               new_ip = mem_rd(addr, 1'b1);
               jump = 1;
               wreg = REG_IP;
               oldv = old_ip;
               newv = new_ip;
            end else fault = 1;
         end
         ip = new_ip;
         pending_records.push_back({fault, jump, newv, oldv, wreg, new_fl, old_fl,
                                    new_ip, old_ip});
      endfunction

      // compare one output record with the oldest prediction
      function void check_record(logic [95:0] got);
         record_type want;
         if (pending_records.size() == 0) begin
            $display("%0t: unexpected record, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = pending_records.pop_front();
         if (got !== {2'b00, want}) begin
            $display("%0t: record mismatch, expected %h, actual %h", $time,
                     {2'b00, want}, got);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [71:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [95:0]  rsp_tdata;

   exec_scoreboard sb = new();
   int  send_gap_pct = 0;
   int  stall_pct = 0;
   bit  hold_off_req = 0;
   int  quiet_cycles = 0;

   x86_16bit_instruction_execute uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // observe transfers on both channels
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_instr(req_tdata[63:0]);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_record(rsp_tdata);
   end

   // receiver: random stalls, or one long hold-off on request
   always begin
      @(posedge clock);
      if (hold_off_req) begin
         rsp_tready <= 1'b0;
         repeat (300) @(posedge clock);
         hold_off_req = 0;
      end else
         rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > 200000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic bit [63:0] pack_instr(bit [4:0] cmd, bit [1:0] dk, bit [2:0] dr,
         bit [1:0] dp, bit [1:0] sk, bit [2:0] sr, bit [1:0] sp, bit [16:0] imm,
         bit [3:0] ba, bit [3:0] bb, bit [16:0] disp, bit [2:0] len);
      return {len, disp, bb, ba, imm, sp, sr, sk, dp, dr, dk, cmd};
   endfunction

   // offer one instruction, with random gaps before it
   task automatic send_instr(bit [63:0] d);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {8'h00, d};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_records.size() != 0) @(posedge clock);
   endtask

   // mostly well-formed instructions on a small memory window
   function automatic bit [63:0] rand_instr();
      bit [4:0] cmd;
      bit [1:0] dk;
      bit [3:0] ba, bb;
      bit [16:0] disp;
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         dk = KIND_REG; cmd = 5'($urandom_range(3));
      end else if (pick < 60) begin
         dk = KIND_MEM; cmd = ($urandom_range(2) == 2) ? CMD_JMP : 5'($urandom_range(1));
      end else if (pick < 90) begin
         dk = KIND_IMM; cmd = 5'($urandom_range(24, 4));
      end else begin
         dk = 2'($urandom_range(3)); cmd = 5'($urandom_range(24));
      end
      ba = ($urandom_range(3) == 0) ? 4'($urandom_range(8)) : 4'd8;
      bb = ($urandom_range(5) == 0) ? 4'($urandom_range(8)) : 4'd8;
      case ($urandom_range(9))
         0: disp = 17'($urandom_range(17'h1FFFF));
         1: disp = 17'h0FFFF;
         default: disp = 17'($urandom_range(31));
      endcase
      return pack_instr(cmd, dk, 3'($urandom_range(7)), 2'($urandom_range(3)),
                        2'($urandom_range(3)), 3'($urandom_range(7)),
                        2'($urandom_range(3)), 17'($urandom_range(17'h1FFFF)),
                        ba, bb, disp, 3'($urandom_range(6, 1)));
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, flags, every jump form, memory wrap, faults
      send_instr(pack_instr(CMD_MOV, KIND_REG, 0, PART_WORD, KIND_IMM, 0, 0, 17'h0FFFF, 8, 8, 0, 1));
      send_instr(pack_instr(CMD_ADD, KIND_REG, 0, PART_WORD, KIND_IMM, 0, 0, 17'h00001, 8, 8, 0, 6));
      send_instr(pack_instr(CMD_MOV, KIND_REG, 3, 2'd2, KIND_IMM, 0, 0, 17'h1FF7F, 8, 8, 0, 2));
      send_instr(pack_instr(CMD_ADD, KIND_REG, 3, 2'd2, KIND_IMM, 0, 0, 17'h00001, 8, 8, 0, 3));
      send_instr(pack_instr(CMD_SUB, KIND_REG, 3, PART_HIGH, KIND_REG, 3, 2'd3, 0, 8, 8, 0, 4));
      send_instr(pack_instr(CMD_CMP, KIND_REG, 2, 2'd3, KIND_REG, 3, 2'd2, 0, 8, 8, 0, 5));
      send_instr(pack_instr(CMD_MOV, KIND_MEM, 0, PART_WORD, KIND_IMM, 0, 0, 17'h01234,
                            8, 8, 17'h0FFFF, 1));
      send_instr(pack_instr(CMD_ADD, KIND_MEM, 0, PART_HIGH, KIND_IMM, 0, 0, 17'h000FF,
                            8, 8, 17'h0FFFF, 2));
      send_instr(pack_instr(CMD_MOV, KIND_REG, 5, PART_WORD, KIND_MEM, 0, 0, 0, 8, 8, 17'h0FFFF, 3));
      send_instr(pack_instr(CMD_MOV, KIND_MEM, 0, PART_WORD, KIND_MEM, 0, 0, 0, 5, 0, 17'h10000, 1));
      send_instr(pack_instr(CMD_JMP, KIND_MEM, 0, PART_WORD, KIND_NONE, 0, 0, 0, 8, 8, 17'h0FFFF, 2));
      send_instr(pack_instr(CMD_JMP, KIND_IMM, 0, 0, KIND_NONE, 0, 0, 17'h10000, 8, 8, 0, 1));
      for (int c = 5; c <= 24; c++)
         send_instr(pack_instr(5'(c), KIND_IMM, 0, 0, KIND_NONE, 0, 0, 17'h00010, 8, 8, 0, 2));
      send_instr(pack_instr(CMD_JMP, KIND_REG, 0, 0, KIND_IMM, 0, 0, 1, 8, 8, 0, 3));
      send_instr(pack_instr(CMD_SUB, KIND_MEM, 0, 0, KIND_IMM, 0, 0, 1, 8, 8, 0, 3));
      send_instr(pack_instr(CMD_CMP, KIND_IMM, 0, 0, KIND_IMM, 0, 0, 1, 8, 8, 0, 3));
      send_instr(pack_instr(CMD_ADD, KIND_NONE, 0, 0, KIND_IMM, 0, 0, 1, 8, 8, 0, 4));

      // random phases with different idling
      for (int ph = 0; ph < 4; ph++) begin
         send_gap_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 59 : 16) : 0;
         stall_pct = (ph == 2) ? 59 : ((ph == 3) ? 16 : 0);
         if (ph == 2) hold_off_req = 1;
         for (int i = 0; i < 100; i++) send_instr(rand_instr());
         if (ph == 1) drain;
      end

      drain;
      repeat (20) @(posedge clock);
      if (sb.pending_records.size() != 0) sb.errors++;
      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
